// File: rtl/ftm_pkg.sv
// shared types and constants of the frame time meter
`default_nettype none
package ftm_pkg;

  localparam int HIST_SIZE = 64;
  localparam int HIST_AW   = (HIST_SIZE > 1) ? $clog2(HIST_SIZE) : 1;
  localparam int CNT_W     = $clog2(HIST_SIZE + 1);

  localparam int TIME_W  = 48;
  localparam int DELTA_W = 32;
  localparam int GAME_W  = 34;
  localparam int SCALE_W = 11;
  localparam int FPS_W   = 28;
  localparam int FRAME_W = 32;
  localparam int SUM_W   = DELTA_W + HIST_AW;
  localparam int PROD_W  = DELTA_W + SCALE_W;

  localparam int DIV_W  = SUM_W;
  localparam int ITER_W = $clog2(DIV_W + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W = 4;

  localparam logic [SCALE_W-1:0] SCALE_MAX   = SCALE_W'(1024);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);
  localparam logic [FPS_W-1:0]   FPS_NUM     = FPS_W'(256000000);
  localparam logic [DIV_W-1:0]   FPS_DIVIDEND =
    {FPS_NUM, {(DIV_W - FPS_W){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_SCALE = 4'd0,
    REG_PAUSED     = 4'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_AVG,
    BK_FPS,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [FRAME_W-1:0] frame;
  } job_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DELTA_W-1:0] divisor;
    logic [ITER_W-1:0]  iters;
  } div_req_t;

endpackage
`default_nettype wire

// File: rtl/ftm_fifo.sv
// short job queue between the front and back parts
`default_nettype none
module ftm_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire ftm_pkg::job_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output ftm_pkg::job_t      rd_data,
  output logic               empty
);

  ftm_pkg::job_t                 store [ftm_pkg::FIFO_DEPTH];
  logic [ftm_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [ftm_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [ftm_pkg::FIFO_AW:0]     count;
  logic                          do_wr;
  logic                          do_rd;

  assign full    = (count == (ftm_pkg::FIFO_AW + 1)'(ftm_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == ftm_pkg::FIFO_AW'(ftm_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == ftm_pkg::FIFO_AW'(ftm_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ftm_front.sv
// front part: takes timestamps, forms the real delta and frame number
`default_nettype none
module ftm_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [ftm_pkg::TIME_W-1:0]  now_us,
  input  wire logic                        q_full,
  output logic                             job_push,
  output ftm_pkg::job_t                    job
);

  logic                          first_flag;
  logic [ftm_pkg::TIME_W-1:0]    last_time;
  logic [ftm_pkg::FRAME_W-1:0]   frames_seen;
  logic [ftm_pkg::TIME_W-1:0]    diff;
  logic                          backward;
  logic [ftm_pkg::DELTA_W-1:0]   delta;

  assign job_push = push && !q_full;
  assign diff     = now_us - last_time;
  assign backward = now_us < last_time;

  always_comb begin
    if (first_flag || backward) begin
      delta = '0;
    end else if (diff[ftm_pkg::TIME_W-1:ftm_pkg::DELTA_W] != '0) begin
      // long frame saturates
      delta = '1;
    end else begin
      delta = diff[ftm_pkg::DELTA_W-1:0];
    end
  end

  assign job.delta = delta;
  assign job.frame = frames_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_flag  <= 1'b1;
      last_time   <= '0;
      frames_seen <= '0;
    end else if (job_push) begin
      first_flag  <= 1'b0;
      last_time   <= now_us;
      frames_seen <= frames_seen + 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ftm_div.sv
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module ftm_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ftm_pkg::div_req_t            req,
  output logic                              done,
  output logic [ftm_pkg::DIV_W-1:0]         quotient
);

  logic                           busy;
  logic [ftm_pkg::ITER_W-1:0]     cnt;
  logic [ftm_pkg::DELTA_W-1:0]    rem;
  logic [ftm_pkg::DIV_W-1:0]      dvd;
  logic [ftm_pkg::DELTA_W-1:0]    dsr;
  logic [ftm_pkg::DELTA_W:0]      rem_sh;
  logic [ftm_pkg::DELTA_W:0]      rem_sub;
  logic                           ge;
  logic                           load;

  assign load    = req.start && !busy;
  assign rem_sh  = {rem, dvd[ftm_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr};
  assign rem_sub = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        busy <= 1'b1;
        cnt  <= req.iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ftm_pkg::ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem      <= '0;
      dvd      <= req.dividend;
      dsr      <= req.divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? rem_sub[ftm_pkg::DELTA_W-1:0] : rem_sh[ftm_pkg::DELTA_W-1:0];
      dvd      <= {dvd[ftm_pkg::DIV_W-2:0], 1'b0};
      quotient <= {quotient[ftm_pkg::DIV_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: rtl/ftm_back.sv
// back part: game time, delta history, average and frame rate
`default_nettype none
module ftm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          job_valid,
  input  wire ftm_pkg::job_t                 job,
  output logic                               job_pop,
  input  wire logic [ftm_pkg::SCALE_W-1:0]   time_scale,
  input  wire logic                          paused,
  input  wire logic                          out_take,
  output logic                               out_valid,
  output logic [ftm_pkg::DELTA_W-1:0]        real_delta_us,
  output logic [ftm_pkg::GAME_W-1:0]         game_delta_us,
  output logic [ftm_pkg::TIME_W-1:0]         game_time_us,
  output logic [ftm_pkg::DELTA_W-1:0]        avg_frame_us,
  output logic [ftm_pkg::FPS_W-1:0]          fps_q8,
  output logic [ftm_pkg::FRAME_W-1:0]        frame_number
);

  ftm_pkg::back_state_t           state;
  ftm_pkg::back_state_t           state_next;
  ftm_pkg::div_req_t              div_req;
  logic                           div_done;
  logic [ftm_pkg::DIV_W-1:0]      div_quo;

  logic [ftm_pkg::DELTA_W-1:0]    hist_mem [ftm_pkg::HIST_SIZE];
  logic [ftm_pkg::HIST_SIZE-1:0]  hist_vld;
  logic [ftm_pkg::DELTA_W-1:0]    rd_data;
  logic                           rd_vld;
  logic [ftm_pkg::HIST_AW-1:0]    slot;
  logic [ftm_pkg::SUM_W-1:0]      history_sum;
  logic [ftm_pkg::CNT_W-1:0]      nonzero_count;
  logic [ftm_pkg::TIME_W-1:0]     game_time;

  logic [ftm_pkg::DELTA_W-1:0]    cur_delta;
  logic [ftm_pkg::FRAME_W-1:0]    cur_frame;
  logic [ftm_pkg::PROD_W-1:0]     prod;
  logic [ftm_pkg::GAME_W-1:0]     res_game_delta;
  logic [ftm_pkg::TIME_W-1:0]     res_game_time;
  logic [ftm_pkg::DELTA_W-1:0]    res_avg;
  logic [ftm_pkg::FPS_W-1:0]      res_fps;

  logic [ftm_pkg::DELTA_W-1:0]    old_val;
  logic [ftm_pkg::GAME_W-1:0]     game_delta_new;
  logic [ftm_pkg::TIME_W-1:0]     game_time_new;
  logic [ftm_pkg::SUM_W-1:0]      sum_next;
  logic [ftm_pkg::CNT_W-1:0]      cnt_next;
  logic                           out_load;

  ftm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // entries never written since reset read as zero
  assign old_val        = rd_vld ? rd_data : '0;
  assign game_delta_new = paused ? '0 : prod[8 +: ftm_pkg::GAME_W];
  assign game_time_new  = game_time + ftm_pkg::TIME_W'(game_delta_new);
  assign sum_next       = history_sum - ftm_pkg::SUM_W'(old_val)
                        + ftm_pkg::SUM_W'(cur_delta);
  assign cnt_next       = nonzero_count
                        - ftm_pkg::CNT_W'(old_val != '0)
                        + ftm_pkg::CNT_W'(cur_delta != '0);

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    div_req    = '0;
    out_load   = 1'b0;
    case (state)
      ftm_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = ftm_pkg::BK_UPDATE;
        end
      end
      ftm_pkg::BK_UPDATE: begin
        if (cnt_next == '0) begin
          state_next = ftm_pkg::BK_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = sum_next;
          div_req.divisor  = ftm_pkg::DELTA_W'(cnt_next);
          div_req.iters    = ftm_pkg::ITER_W'(ftm_pkg::DIV_W);
          state_next       = ftm_pkg::BK_AVG;
        end
      end
      ftm_pkg::BK_AVG: begin
        if (div_done) begin
          // avg is at least one here since every counted entry is nonzero
          div_req.start    = 1'b1;
          div_req.dividend = ftm_pkg::FPS_DIVIDEND;
          div_req.divisor  = div_quo[ftm_pkg::DELTA_W-1:0];
          div_req.iters    = ftm_pkg::ITER_W'(ftm_pkg::FPS_W);
          state_next       = ftm_pkg::BK_FPS;
        end
      end
      ftm_pkg::BK_FPS: begin
        if (div_done) begin
          state_next = ftm_pkg::BK_DONE;
        end
      end
      ftm_pkg::BK_DONE: begin
        if (!out_valid || out_take) begin
          out_load   = 1'b1;
          state_next = ftm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = ftm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ftm_pkg::BK_IDLE;
      hist_vld      <= '0;
      rd_vld        <= 1'b0;
      slot          <= '0;
      history_sum   <= '0;
      nonzero_count <= '0;
      game_time     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (job_pop) begin
        rd_vld <= hist_vld[slot];
      end
      if (state == ftm_pkg::BK_UPDATE) begin
        hist_vld[slot] <= 1'b1;
        history_sum    <= sum_next;
        nonzero_count  <= cnt_next;
        game_time      <= game_time_new;
        slot <= (slot == ftm_pkg::HIST_AW'(ftm_pkg::HIST_SIZE - 1)) ? '0 : slot + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // history ring
  always_ff @(posedge clk) begin
    if (job_pop) begin
      rd_data <= hist_mem[slot];
    end
    if (state == ftm_pkg::BK_UPDATE) begin
      hist_mem[slot] <= cur_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_delta <= job.delta;
      cur_frame <= job.frame;
      prod      <= ftm_pkg::PROD_W'(job.delta) * ftm_pkg::PROD_W'(time_scale);
    end
    if (state == ftm_pkg::BK_UPDATE) begin
      res_game_delta <= game_delta_new;
      res_game_time  <= game_time_new;
      if (cnt_next == '0) begin
        res_avg <= '0;
        res_fps <= '0;
      end
    end
    if (state == ftm_pkg::BK_AVG && div_done) begin
      res_avg <= div_quo[ftm_pkg::DELTA_W-1:0];
    end
    if (state == ftm_pkg::BK_FPS && div_done) begin
      res_fps <= div_quo[ftm_pkg::FPS_W-1:0];
    end
    if (out_load) begin
      real_delta_us <= cur_delta;
      game_delta_us <= res_game_delta;
      game_time_us  <= res_game_time;
      avg_frame_us  <= res_avg;
      fps_q8        <= res_fps;
      frame_number  <= cur_frame;
    end
  end

endmodule
`default_nettype wire

// File: rtl/frame_time_meter.sv
// frame time meter top level: config registers, front, job queue, back
// path from push transfer to result shown: queue and update, the average and the frame rate
//   on one serial divider, then the output register
// back part takes a new frame only when done with the last, set by the two passes through the
//   serial divider, skipped when no history entry is nonzero. the job queue holds 4 frames meanwhile
// reset: synchronous, clears all history at once through per-entry valid bits, no clearing pass
`default_nettype none
module frame_time_meter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [ftm_pkg::TIME_W-1:0]      now_us,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [ftm_pkg::DELTA_W-1:0]          real_delta_us,
  output logic [ftm_pkg::GAME_W-1:0]           game_delta_us,
  output logic [ftm_pkg::TIME_W-1:0]           game_time_us,
  output logic [ftm_pkg::DELTA_W-1:0]          avg_frame_us,
  output logic [ftm_pkg::FPS_W-1:0]            fps_q8,
  output logic [ftm_pkg::FRAME_W-1:0]          frame_number,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ftm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ftm_pkg::SCALE_W-1:0]     cfg_data
);

  logic [ftm_pkg::SCALE_W-1:0]  time_scale;
  logic                         paused;
  logic                         q_full;
  logic                         q_empty;
  logic                         job_push;
  logic                         job_pop;
  ftm_pkg::job_t                job_in;
  ftm_pkg::job_t                job_out;
  logic                         out_valid;
  logic                         out_take;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign empty     = !out_valid;
  assign out_take  = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_scale <= ftm_pkg::SCALE_RESET;
      paused     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ftm_pkg::REG_TIME_SCALE: begin
          time_scale <= (cfg_data > ftm_pkg::SCALE_MAX) ? ftm_pkg::SCALE_MAX : cfg_data;
        end
        ftm_pkg::REG_PAUSED: begin
          paused <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  ftm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .now_us   (now_us),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (job_in)
  );

  ftm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (q_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (q_empty)
  );

  ftm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (!q_empty),
    .job           (job_out),
    .job_pop       (job_pop),
    .time_scale    (time_scale),
    .paused        (paused),
    .out_take      (out_take),
    .out_valid     (out_valid),
    .real_delta_us (real_delta_us),
    .game_delta_us (game_delta_us),
    .game_time_us  (game_time_us),
    .avg_frame_us  (avg_frame_us),
    .fps_q8        (fps_q8),
    .frame_number  (frame_number)
  );

`ifndef SYNTHESIS
  // nothing waits on the result side right after reset
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result shown right after reset");

  // scale never exceeds 4.0
  a_game_delta_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (game_delta_us <= {real_delta_us, 2'b00}))
    else $error("game delta above four times real delta");

  a_paused_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && paused) |-> (game_delta_us == '0))
    else $error("game delta nonzero while paused");

  // no nonzero history entries means no rate
  a_fps_needs_avg: assert property (@(posedge clk) disable iff (rst)
    (!empty && avg_frame_us == '0) |-> (fps_q8 == '0))
    else $error("frame rate without an average");
`endif

endmodule
`default_nettype wire

// File: tb/frame_time_meter_test.sv
// frame time meter testbench: directed frame table, then random frames checked by a predictor
`timescale 1ns / 1ps
module frame_time_meter_test;

  localparam int               RANDOM_FRAMES = 1200;
  localparam int               STALL_LIMIT   = 2000;
  localparam int               DRAIN_CYCLES  = 200;
  localparam longint unsigned  FPS_NUMERATOR = 64'd256000000;
  localparam logic [ftm_pkg::SCALE_W-1:0] SCALE_CEILING = 11'd1024;
  localparam logic [ftm_pkg::SCALE_W-1:0] SCALE_UNITY   = 11'd256;
  localparam logic [ftm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_EVEN = 4'd2;
  localparam logic [ftm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_ODD  = 4'd15;

  typedef struct packed {
    logic [ftm_pkg::DELTA_W-1:0] real_delta;
    logic [ftm_pkg::GAME_W-1:0]  game_delta;
    logic [ftm_pkg::TIME_W-1:0]  game_time;
    logic [ftm_pkg::DELTA_W-1:0] avg_frame;
    logic [ftm_pkg::FPS_W-1:0]   fps;
    logic [ftm_pkg::FRAME_W-1:0] frame;
  } meter_result_t;

  typedef enum logic [0:0] {
    ROW_FRAME,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [ftm_pkg::CFG_IDX_W-1:0] index;
    logic [ftm_pkg::SCALE_W-1:0]   data;
    logic [ftm_pkg::TIME_W-1:0]    stamp;
    logic                          typed;
    meter_result_t                 want;
  } stim_row_t;

  logic                          clk;
  logic                          rst;
  logic                          push;
  logic                          full;
  logic [ftm_pkg::TIME_W-1:0]    now_us;
  logic                          empty;
  logic                          pop;
  logic [ftm_pkg::DELTA_W-1:0]   real_delta_us;
  logic [ftm_pkg::GAME_W-1:0]    game_delta_us;
  logic [ftm_pkg::TIME_W-1:0]    game_time_us;
  logic [ftm_pkg::DELTA_W-1:0]   avg_frame_us;
  logic [ftm_pkg::FPS_W-1:0]     fps_q8;
  logic [ftm_pkg::FRAME_W-1:0]   frame_number;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ftm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ftm_pkg::SCALE_W-1:0]   cfg_data;

  frame_time_meter DUT (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .now_us        (now_us),
    .empty         (empty),
    .pop           (pop),
    .real_delta_us (real_delta_us),
    .game_delta_us (game_delta_us),
    .game_time_us  (game_time_us),
    .avg_frame_us  (avg_frame_us),
    .fps_q8        (fps_q8),
    .frame_number  (frame_number),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor copy of registers and state
  logic [ftm_pkg::SCALE_W-1:0] scale_reg;
  logic                        paused_reg;
  logic                        first_pending;
  logic [ftm_pkg::TIME_W-1:0]  prev_now;
  logic [ftm_pkg::DELTA_W-1:0] hist [ftm_pkg::HIST_SIZE];
  int                          hist_slot;
  longint unsigned             hist_sum;
  int                          hist_nonzero;
  logic [ftm_pkg::TIME_W-1:0]  game_clock;
  logic [ftm_pkg::FRAME_W-1:0] frame_count;

  meter_result_t               expected_frames[$];
  stim_row_t                   directed_rows[$];
  logic [ftm_pkg::TIME_W-1:0]  stim_clock;
  bit                          calm;
  int                          mismatches;
  int                          stall_cycles;

  function automatic meter_result_t meter_predict(input logic [ftm_pkg::TIME_W-1:0] t);
    meter_result_t               r;
    logic [ftm_pkg::TIME_W-1:0]  diff;
    logic [ftm_pkg::DELTA_W-1:0] delta;
    logic [ftm_pkg::DELTA_W-1:0] old;
    logic [ftm_pkg::PROD_W-1:0]  prod;
    logic [ftm_pkg::GAME_W-1:0]  gdelta;
    longint unsigned             avg;
    longint unsigned             fps;
    delta = '0;
    if (first_pending) begin
      first_pending = 1'b0;
    end else if (t >= prev_now) begin
      diff  = t - prev_now;
      delta = (diff > ftm_pkg::TIME_W'(32'hFFFF_FFFF)) ? '1 : diff[ftm_pkg::DELTA_W-1:0];
    end
    prev_now = t;
    prod   = ftm_pkg::PROD_W'(delta) * ftm_pkg::PROD_W'(scale_reg);
    gdelta = paused_reg ? '0 : ftm_pkg::GAME_W'(prod >> 8);
    game_clock = game_clock + ftm_pkg::TIME_W'(gdelta);
    // ring keeps zero entries but leaves them out of sum and count
    old = hist[hist_slot];
    hist_sum = hist_sum - old + delta;
    if (old != 0) hist_nonzero--;
    if (delta != 0) hist_nonzero++;
    hist[hist_slot] = delta;
    hist_slot = (hist_slot + 1) % ftm_pkg::HIST_SIZE;
    avg = 0;
    fps = 0;
    if (hist_nonzero != 0) begin
      avg = hist_sum / longint'(hist_nonzero);
      if (avg != 0) fps = FPS_NUMERATOR / avg;
    end
    r.real_delta = delta;
    r.game_delta = gdelta;
    r.game_time  = game_clock;
    r.avg_frame  = ftm_pkg::DELTA_W'(avg);
    r.fps        = ftm_pkg::FPS_W'(fps);
    r.frame      = frame_count;
    frame_count  = frame_count + 1'b1;
    return r;
  endfunction

  function automatic void meter_configure(input logic [ftm_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [ftm_pkg::SCALE_W-1:0] data);
    case (idx)
      ftm_pkg::REG_TIME_SCALE: scale_reg = (data > SCALE_CEILING) ? SCALE_CEILING : data;
      ftm_pkg::REG_PAUSED:     paused_reg = data[0];
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ftm_pkg::TIME_W-1:0] next_stamp(input bit still);
    int                         r;
    logic [31:0]                hi;
    logic [31:0]                lo;
    logic [ftm_pkg::TIME_W-1:0] step;
    r  = $urandom_range(0, 99);
    hi = $urandom;
    lo = $urandom;
    if (still) begin
      if (r < 90) return stim_clock;
      return stim_clock + $urandom_range(1, 40000);
    end
    if (r < 70) return stim_clock + $urandom_range(1, 40000);
    if (r < 80) return stim_clock + $urandom_range(40001, 3000000);
    if (r < 86) return stim_clock;
    if (r < 91) begin
      step = $urandom_range(1, 100000);
      return (stim_clock > step) ? stim_clock - step : '0;
    end
    if (r < 95) return stim_clock + {15'd0, 1'b1, lo};
    // right around the saturation point
    if (r < 97) return stim_clock + 48'h1_0000_0000 - ftm_pkg::TIME_W'(hi[1:0]);
    return {hi[15:0], lo};
  endfunction

  function automatic void add_frame_row(input logic [ftm_pkg::TIME_W-1:0] t,
                                        input logic typed, input meter_result_t want);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_FRAME;
    row.stamp = t;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg_row(input logic [ftm_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [ftm_pkg::SCALE_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_CFG;
    row.index = idx;
    row.data  = data;
    directed_rows.push_back(row);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer with push still high
  task automatic push_frame(input logic [ftm_pkg::TIME_W-1:0] t, input logic typed,
                            input meter_result_t want);
    int            gap;
    meter_result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push   = 1'b1;
    now_us = t;
    do @(posedge clk); while (full);
    pred = meter_predict(t);
    expected_frames.push_back(typed ? want : pred);
    stim_clock = t;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
  endtask

  task automatic write_config(input logic [ftm_pkg::CFG_IDX_W-1:0] idx,
                              input logic [ftm_pkg::SCALE_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    meter_configure(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic compare_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
    end
  endtask

  initial begin : result_side
    int            gap;
    meter_result_t want;
    pop = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      if (expected_frames.size() == 0) begin
        mismatches++;
        $display("%0t: result frame %0d with nothing expected", $time, frame_number);
      end else begin
        want = expected_frames.pop_front();
        compare_field("real_delta_us", 64'(want.real_delta), 64'(real_delta_us));
        compare_field("game_delta_us", 64'(want.game_delta), 64'(game_delta_us));
        compare_field("game_time_us", 64'(want.game_time), 64'(game_time_us));
        compare_field("avg_frame_us", 64'(want.avg_frame), 64'(avg_frame_us));
        compare_field("fps_q8", 64'(want.fps), 64'(fps_q8));
        compare_field("frame_number", 64'(want.frame), 64'(frame_number));
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int                            sent;
    int                            run;
    int                            writes;
    bit                            still;
    stim_row_t                     row;
    logic [ftm_pkg::CFG_IDX_W-1:0] idx;
    logic [ftm_pkg::SCALE_W-1:0]   data;
    rst          = 1'b1;
    push         = 1'b0;
    now_us       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = ftm_pkg::REG_TIME_SCALE;
    cfg_data     = '0;
    calm         = 1'b0;
    mismatches   = 0;
    stall_cycles = 0;
    stim_clock   = '0;
    scale_reg     = SCALE_UNITY;
    paused_reg    = 1'b0;
    first_pending = 1'b1;
    prev_now      = '0;
    hist_slot     = 0;
    hist_sum      = 0;
    hist_nonzero  = 0;
    game_clock    = '0;
    frame_count   = '0;
    for (int i = 0; i < ftm_pkg::HIST_SIZE; i++) hist[i] = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // first frame after reset reports all zeros
    add_frame_row(48'd1000, 1'b1, '0);
    add_frame_row(48'd2000, 1'b1,
                  meter_result_t'{ftm_pkg::DELTA_W'(1000), ftm_pkg::GAME_W'(1000),
                                  ftm_pkg::TIME_W'(1000), ftm_pkg::DELTA_W'(1000),
                                  ftm_pkg::FPS_W'(256000), ftm_pkg::FRAME_W'(1)});
    add_frame_row(48'd2000, 1'b0, '0);
    add_frame_row(48'd256, 1'b0, '0);
    add_frame_row(48'h1_0000_0105, 1'b0, '0);
    add_frame_row(48'h2_0000_0104, 1'b0, '0);
    add_cfg_row(ftm_pkg::REG_TIME_SCALE, 11'd0);
    add_frame_row(48'h2_0000_0114, 1'b0, '0);
    add_cfg_row(ftm_pkg::REG_TIME_SCALE, SCALE_CEILING);
    add_frame_row(48'h3_0000_0113, 1'b0, '0);
    add_cfg_row(ftm_pkg::REG_TIME_SCALE, 11'h7FF);
    add_frame_row(48'h3_0000_011A, 1'b0, '0);
    add_cfg_row(ftm_pkg::REG_TIME_SCALE, 11'd1);
    add_frame_row(48'h3_0000_0219, 1'b0, '0);
    add_cfg_row(ftm_pkg::REG_PAUSED, 11'd1);
    add_frame_row(48'h3_0000_040D, 1'b0, '0);
    add_cfg_row(ftm_pkg::REG_PAUSED, 11'd0);
    add_cfg_row(ftm_pkg::REG_TIME_SCALE, 11'd384);
    add_cfg_row(CFG_IDX_SPARE_EVEN, 11'd0);
    add_cfg_row(CFG_IDX_SPARE_ODD, 11'h7FF);
    add_frame_row(48'h3_0000_07F5, 1'b0, '0);
    add_frame_row(48'hFFFF_FFFF_FFFF, 1'b0, '0);
    add_frame_row(48'd0, 1'b0, '0);
    add_frame_row(48'd1, 1'b0, '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_FRAME) begin
        push_frame(row.stamp, row.typed, row.want);
      end else begin
        wait_drained();
        write_config(row.index, row.data);
      end
    end

    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      // registers change only with the block drained
      wait_drained();
      writes = $urandom_range(0, 3);
      repeat (writes) begin
        if ($urandom_range(0, 9) < 7)
          idx = $urandom_range(0, 1) ? ftm_pkg::REG_PAUSED : ftm_pkg::REG_TIME_SCALE;
        else
          idx = ftm_pkg::CFG_IDX_W'($urandom);
        case ($urandom_range(0, 5))
          0: data = '0;
          1: data = SCALE_CEILING;
          2: data = '1;
          3: data = SCALE_UNITY;
          4: data = ftm_pkg::SCALE_W'($urandom_range(0, 1024));
          default: data = ftm_pkg::SCALE_W'($urandom);
        endcase
        write_config(idx, data);
      end
      calm  = ($urandom_range(0, 3) == 0);
      still = ($urandom_range(0, 5) == 0);
      run   = $urandom_range(20, 140);
      repeat (run) begin
        push_frame(next_stamp(still), 1'b0, '0);
        sent++;
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ftm_pkg.sv
rtl/ftm_fifo.sv
rtl/ftm_front.sv
rtl/ftm_div.sv
rtl/ftm_back.sv
rtl/frame_time_meter.sv
tb/frame_time_meter_test.sv
